>>> design/pid_trapezoid_antiwindup_defines.svh
// Assertion macros shared by the PID controller RTL.
`ifndef PID_TRAPEZOID_ANTIWINDUP_DEFINES_SVH
`define PID_TRAPEZOID_ANTIWINDUP_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset
`define PTA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset
`define PTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pta_pkg.sv
// Shared types and constants of the PID controller.
package pta_pkg;

  // time step is unsigned Q0.16
  localparam int unsigned DT_BITS = 16;
  // integral increment drops the time-step fraction and the trapezoid halving
  localparam int unsigned INC_SHIFT = DT_BITS + 1;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [2:0] {
    REG_KP, REG_KI, REG_KD, REG_OUT_LOW, REG_OUT_HIGH, REG_INTEG_LOW, REG_INTEG_HIGH
  } reg_idx_e;

  // which product the shared multiplier is forming
  typedef enum logic [1:0] {MSEL_P, MSEL_INC, MSEL_I, MSEL_D} msel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_P_GO, ST_P_WAIT, ST_INC_GO, ST_INC_WAIT, ST_I_GO, ST_I_WAIT,
    ST_ICAND, ST_DIV_GO, ST_DIV_WAIT, ST_D_GO, ST_D_WAIT, ST_SUM, ST_RES, ST_DONE
  } state_e;

  typedef struct packed {
    logic  accept;
    logic  load;
    logic  mul_start;
    msel_e mul_sel;
    logic  div_start;
    logic  icand_en;
    logic  sum_en;
    logic  res_en;
    logic  out_load;
  } pta_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic in_skip;
    logic out_busy;
  } pta_sts_t;

endpackage

>>> design/pid_trapezoid_antiwindup.sv
// Top level of the PID controller with trapezoidal integral and anti-windup.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: setpoint, measurement, time_step
//                                         tuser: action
//   m_axis    out  tvalid/tready          tdata: drive; tuser: skipped
//   cfg       in   cfg_we_i (no wait)     cfg_index_i, cfg_wdata_i
//
// A compute item makes four passes through the shared 8-bit-per-cycle multiplier
// and one bit-serial rate division; a reset or zero-time-step item skips both.
// One item is in flight at a time; a finished result waits in the output register
// while the next item is taken. Reset clears the gains, limits and loop state.
`include "pid_trapezoid_antiwindup_defines.svh"

module pid_trapezoid_antiwindup
  import pta_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // setpoint, measurement, time_step (from bit 0), zero fill
  input  logic [((2*DATA_WIDTH+DT_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // action
  input  logic [0:0]                                 s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // drive, zero fill
  output logic [((DATA_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
  // skipped
  output logic [0:0]                                 m_axis_tuser,
  input  logic                                       cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]                    cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                      cfg_wdata_i
);

  localparam int unsigned W       = DATA_WIDTH;
  localparam int unsigned OUT_TDW = ((DATA_WIDTH + 7) / 8) * 8;

  pta_cmd_t     cmd;
  pta_sts_t     sts;
  logic [W-1:0] out_drive;
  logic         out_skipped;

  pta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pta_dp #(.W(W), .FRAC(FRAC_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_action_i      (s_axis_tuser[0]),
    .in_setpoint_i    (s_axis_tdata[W-1:0]),
    .in_measurement_i (s_axis_tdata[2*W-1:W]),
    .in_time_step_i   (s_axis_tdata[2*W+DT_BITS-1:2*W]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_drive_o      (out_drive),
    .out_skipped_o    (out_skipped)
  );

  assign m_axis_tdata    = OUT_TDW'(out_drive);
  assign m_axis_tuser[0] = out_skipped;

  // an accepted item blocks the input until it is finished
  `PTA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
  // skipped results carry a zero drive
  `PTA_ASSERT_IMPL(a_skip_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "skipped result with nonzero drive")
  // multiplier and divider never finish together
  `PTA_ASSERT_IMPL(a_unit_excl, sts.mul_done, !sts.div_done, "multiplier and divider done together")

endmodule

>>> design/pta_mul.sv
// Shared sequential multiplier: 8 multiplier bits per cycle, shift and saturate.
module pta_mul
  import pta_pkg::*;
#(
  parameter int unsigned W    = 32,
  parameter int unsigned FRAC = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W:0]   a_i,
  input  logic [W:0]   b_i,
  input  logic         frac_sh_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int unsigned PW   = 2 * W + 2;
  localparam int unsigned MDIG = (W + 8) / 8;
  localparam int unsigned CW   = $clog2(MDIG + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

  logic          busy_q, fin_q, done_q, neg_q, frac_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] mcand_q, acc_q;
  logic [W:0]    mplier_q;
  logic [W-1:0]  res_q;

  logic [W:0]    mag_a, mag_b;
  logic [PW+7:0] prod;
  logic [PW-1:0] shifted, lim, sat_mag;
  logic [W-1:0]  res_d;

  assign mag_a = a_i[W] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[W] ? (~b_i + 1'b1) : b_i;
  assign prod  = mcand_q * mplier_q[7:0];

  // shift out the fraction, truncating the magnitude, then saturate
  always_comb begin
    shifted = frac_q ? (acc_q >> FRAC) : (acc_q >> INC_SHIFT);
    lim     = HALF - PW'(!neg_q);
    sat_mag = (shifted > lim) ? lim : shifted;
    res_d   = neg_q ? (~sat_mag[W-1:0] + 1'b1) : sat_mag[W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MDIG - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // operands, accumulator and result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= PW'(mag_a);
      mplier_q <= mag_b;
      acc_q    <= '0;
      neg_q    <= a_i[W] ^ b_i[W];
      frac_q   <= frac_sh_i;
    end else if (busy_q) begin
      acc_q    <= acc_q + prod[PW-1:0];
      mcand_q  <= mcand_q << 8;
      mplier_q <= mplier_q >> 8;
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> design/pta_div.sv
// Restoring divider for the measurement rate: one quotient bit per cycle.
module pta_div
  import pta_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [W:0]         diff_i,
  input  logic [DT_BITS-1:0] t_i,
  output logic               done_o,
  output logic [W-1:0]       rate_o
);

  localparam int unsigned NB = W + 1 + DT_BITS;
  localparam int unsigned CW = $clog2(NB + 1);
  localparam logic [NB-1:0] HALF = NB'(1) << (W - 1);

  logic               busy_q, fin_q, done_q, neg_q;
  logic [CW-1:0]      cnt_q;
  logic [NB-1:0]      num_q;
  logic [DT_BITS:0]   rem_q;
  logic [DT_BITS-1:0] t_q;
  logic [W-1:0]       rate_q;

  logic [W:0]         mag;
  logic [DT_BITS:0]   trial;
  logic               ge;
  logic [NB-1:0]      lim, quo_sat;
  logic [W-1:0]       rate_d;

  assign mag   = diff_i[W] ? (~diff_i + 1'b1) : diff_i;
  assign trial = {rem_q[DT_BITS-1:0], num_q[NB-1]};
  assign ge    = trial >= {1'b0, t_q};

  // saturate the signed quotient
  always_comb begin
    lim     = HALF - NB'(!neg_q);
    quo_sat = (num_q > lim) ? lim : num_q;
    rate_d  = neg_q ? (~quo_sat[W-1:0] + 1'b1) : quo_sat[W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NB - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag, {DT_BITS{1'b0}}};
      rem_q <= '0;
      t_q   <= t_i;
      neg_q <= diff_i[W];
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, t_q}) : trial;
      num_q <= {num_q[NB-2:0], ge};
    end
    if (fin_q) begin
      rate_q <= rate_d;
    end
  end

  assign done_o = done_q;
  assign rate_o = rate_q;

endmodule

>>> design/pta_dp.sv
// Datapath: registers, loop state, operand selection, sums, clamps, output register.
module pta_dp
  import pta_pkg::*;
#(
  parameter int unsigned W    = 32,
  parameter int unsigned FRAC = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pta_cmd_t                cmd_i,
  output pta_sts_t                sts_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [W-1:0]            cfg_wdata_i,
  input  logic                    in_action_i,
  input  logic [W-1:0]            in_setpoint_i,
  input  logic [W-1:0]            in_measurement_i,
  input  logic [DT_BITS-1:0]      in_time_step_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [W-1:0]            out_drive_o,
  output logic                    out_skipped_o
);

  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // sign-extend to W+2
  function automatic logic [W+1:0] ext(input logic [W-1:0] v);
    return {{2{v[W-1]}}, v};
  endfunction

  function automatic logic [W-1:0] sat_w(input logic [W+1:0] x);
    logic ovf;
    ovf = x[W+1:W-1] != {3{x[W+1]}};
    if (ovf) return x[W+1] ? VMIN : VMAX;
    return x[W-1:0];
  endfunction

  // high limit checked first
  function automatic logic [W-1:0] clamp_hl(input logic [W+1:0] x,
                                            input logic [W-1:0] lo,
                                            input logic [W-1:0] hi);
    if ($signed(x) > $signed(ext(hi))) return hi;
    if ($signed(x) < $signed(ext(lo))) return lo;
    return x[W-1:0];
  endfunction

  logic [W-1:0]       kp_q, ki_q, kd_q, olo_q, ohi_q, ilo_q, ihi_q;
  logic [W-1:0]       sp_q, ms_q, e0_q, e1_q, pm_q;
  logic [DT_BITS-1:0] t_q;
  logic [W-1:0]       p_q, inc_q, mi_q, rate_q, d_q, icand_q, res_q;
  logic [W-1:0]       integ_q, prev_meas_q, prev_err_q;
  logic               primed_q, skip_q;
  msel_e              msel_q;
  logic               out_valid_q, out_skip_q;
  logic [W-1:0]       out_drive_q;

  logic [W:0]         mul_a, mul_b;
  logic               mul_frac;
  logic               mul_done, div_done;
  logic [W-1:0]       mul_res, div_rate;
  logic [W-1:0]       e0_d;
  logic [W:0]         div_diff;
  logic [W+1:0]       ocand, rsum;
  logic               commit;

  // configuration writes; unused index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      olo_q <= '0;
      ohi_q <= '0;
      ilo_q <= '0;
      ihi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_KP:         kp_q  <= cfg_wdata_i;
        REG_KI:         ki_q  <= cfg_wdata_i;
        REG_KD:         kd_q  <= cfg_wdata_i;
        REG_OUT_LOW:    olo_q <= cfg_wdata_i;
        REG_OUT_HIGH:   ohi_q <= cfg_wdata_i;
        REG_INTEG_LOW:  ilo_q <= cfg_wdata_i;
        REG_INTEG_HIGH: ihi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MSEL_P: begin
        mul_a    = {kp_q[W-1], kp_q};
        mul_b    = {e0_q[W-1], e0_q};
        mul_frac = 1'b1;
      end
      MSEL_INC: begin
        mul_a    = {e0_q[W-1], e0_q} + {e1_q[W-1], e1_q};
        mul_b    = (W+1)'(t_q);
        mul_frac = 1'b0;
      end
      MSEL_I: begin
        mul_a    = {ki_q[W-1], ki_q};
        mul_b    = {inc_q[W-1], inc_q};
        mul_frac = 1'b1;
      end
      default: begin
        mul_a    = {kd_q[W-1], kd_q};
        mul_b    = {rate_q[W-1], rate_q};
        mul_frac = 1'b1;
      end
    endcase
  end

  pta_mul #(.W(W), .FRAC(FRAC)) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .frac_sh_i (mul_frac),
    .done_o    (mul_done),
    .res_o     (mul_res)
  );

  assign div_diff = {ms_q[W-1], ms_q} - {pm_q[W-1], pm_q};

  pta_div #(.W(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .diff_i  (div_diff),
    .t_i     (t_q),
    .done_o  (div_done),
    .rate_o  (div_rate)
  );

  assign e0_d  = sat_w(ext(sp_q) - ext(ms_q));
  assign ocand = ext(p_q) + ext(icand_q) + ext(d_q);
  assign rsum  = ext(p_q) + ext(integ_q) + ext(d_q);

  // commit when in range, or when the error pulls back out of saturation
  always_comb begin
    commit = 1'b0;
    if ($signed(ocand) <= $signed(ext(ohi_q)) && $signed(ocand) >= $signed(ext(olo_q)))
      commit = 1'b1;
    else if ($signed(ocand) > $signed(ext(ohi_q)) && e0_q[W-1])
      commit = 1'b1;
    else if ($signed(ocand) < $signed(ext(olo_q)) && !e0_q[W-1] && (e0_q != '0))
      commit = 1'b1;
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      prev_meas_q <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
    end else if (cmd_i.accept && in_action_i) begin
      primed_q    <= 1'b0;
      prev_meas_q <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
    end else begin
      if (cmd_i.sum_en && commit) begin
        integ_q <= icand_q;
      end
      if (cmd_i.res_en) begin
        primed_q    <= 1'b1;
        prev_meas_q <= ms_q;
        prev_err_q  <= e0_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sp_q   <= in_setpoint_i;
      ms_q   <= in_measurement_i;
      t_q    <= in_time_step_i;
      res_q  <= '0;
      skip_q <= in_action_i | (in_time_step_i == '0);
    end
    if (cmd_i.load) begin
      e0_q <= e0_d;
      e1_q <= primed_q ? prev_err_q : e0_d;
      pm_q <= primed_q ? prev_meas_q : ms_q;
    end
    if (cmd_i.mul_start) begin
      msel_q <= cmd_i.mul_sel;
    end
    if (mul_done) begin
      case (msel_q)
        MSEL_P:   p_q   <= mul_res;
        MSEL_INC: inc_q <= mul_res;
        MSEL_I:   mi_q  <= mul_res;
        default:  d_q   <= (mul_res == VMIN) ? VMAX : (~mul_res + 1'b1);
      endcase
    end
    if (div_done) begin
      rate_q <= div_rate;
    end
    if (cmd_i.icand_en) begin
      icand_q <= clamp_hl(ext(sat_w(ext(integ_q) + ext(mi_q))), ilo_q, ihi_q);
    end
    if (cmd_i.res_en) begin
      res_q <= clamp_hl(rsum, olo_q, ohi_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_drive_q <= res_q;
      out_skip_q  <= skip_q;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.in_skip  = in_action_i | (in_time_step_i == '0);
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_drive_o   = out_drive_q;
  assign out_skipped_o = out_skip_q;

endmodule

>>> design/pta_ctrl.sv
// Controller: sequences one item through the multiplier, divider and sums.
module pta_ctrl
  import pta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pta_sts_t sts_i,
  output pta_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = sts_i.in_skip ? ST_DONE : ST_LOAD;
      ST_LOAD:     state_d = ST_P_GO;
      ST_P_GO:     state_d = ST_P_WAIT;
      ST_P_WAIT:   if (sts_i.mul_done) state_d = ST_INC_GO;
      ST_INC_GO:   state_d = ST_INC_WAIT;
      ST_INC_WAIT: if (sts_i.mul_done) state_d = ST_I_GO;
      ST_I_GO:     state_d = ST_I_WAIT;
      ST_I_WAIT:   if (sts_i.mul_done) state_d = ST_ICAND;
      ST_ICAND:    state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (sts_i.div_done) state_d = ST_D_GO;
      ST_D_GO:     state_d = ST_D_WAIT;
      ST_D_WAIT:   if (sts_i.mul_done) state_d = ST_SUM;
      ST_SUM:      state_d = ST_RES;
      ST_RES:      state_d = ST_DONE;
      ST_DONE:     if (!sts_i.out_busy) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MSEL_P;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_LOAD:   cmd_o.load = 1'b1;
      ST_P_GO:   cmd_o.mul_start = 1'b1;
      ST_INC_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_INC;
      end
      ST_I_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_I;
      end
      ST_ICAND:  cmd_o.icand_en = 1'b1;
      ST_DIV_GO: cmd_o.div_start = 1'b1;
      ST_D_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_D;
      end
      ST_SUM:    cmd_o.sum_en = 1'b1;
      ST_RES:    cmd_o.res_en = 1'b1;
      ST_DONE:   cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

>>> test/tb_pid_trapezoid_antiwindup.sv
// Self-checking testbench of the PID controller: directed and random transactions.
module tb_pid_trapezoid_antiwindup;
  import pta_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int TDW = ((2*DW+DT_BITS+7)/8)*8;

  typedef struct packed {
    logic [DW-1:0] drive;
    logic          skipped;
  } pid_out_t;

  // Controller predictor plus queue of expected outputs
  class pid_scoreboard;
    longint gain_p, gain_i, gain_d, lim_olo, lim_ohi, lim_ilo, lim_ihi;
    bit     primed;
    longint last_meas, last_err, integ;
    pid_out_t pending[$];
    int     errors;

    function longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // exact product, shifted toward zero, saturated
    function longint mul_shift(longint a, longint b, int sh);
      logic signed [127:0] prod;
      logic        [127:0] m;
      bit neg;
      prod = 128'(signed'(a)) * 128'(signed'(b));
      neg = prod < 0;
      m = neg ? -prod : prod;
      m = m >> sh;
      if (neg) begin
        if (m > 128'd2147483648) return -64'sd2147483648;
        return -longint'(m);
      end
      if (m > 128'd2147483647) return 64'sd2147483647;
      return longint'(m);
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function void clear_loop();
      primed = 0; last_meas = 0; last_err = 0; integ = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DW-1:0] v);
      longint s;
      s = longint'(signed'(v));
      case (idx)
        REG_KP: gain_p = s;
        REG_KI: gain_i = s;
        REG_KD: gain_d = s;
        REG_OUT_LOW: lim_olo = s;
        REG_OUT_HIGH: lim_ohi = s;
        REG_INTEG_LOW: lim_ilo = s;
        REG_INTEG_HIGH: lim_ihi = s;
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted input transaction
    function void note_input(bit act, logic [DW-1:0] sp_v, logic [DW-1:0] ms_v,
                             logic [15:0] dt);
      longint sp, ms, e0, e1, p, d, rate, inc, icand, ocand, res, diff;
      longint unsigned dmag, q;
      pid_out_t r;
      sp = longint'(signed'(sp_v));
      ms = longint'(signed'(ms_v));
      r.skipped = 1;
      r.drive = '0;
      if (act) clear_loop();
      else if (dt != 0) begin
        e0 = sat32(sp - ms);
        if (!primed) begin
          last_meas = ms; last_err = e0; primed = 1;
        end
        e1 = last_err;
        p = mul_shift(gain_p, e0, FB);
        diff = ms - last_meas;
        dmag = diff < 0 ? -diff : diff;
        q = dmag / dt;
        if (q > 64'd32768) q = 64'd2147483648;
        else q = (q << 16) + (((dmag % dt) << 16) / dt);
        if (diff < 0) rate = q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
        else rate = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
        d = sat32(-mul_shift(gain_d, rate, FB));
        inc = mul_shift(e0 + e1, longint'(dt), INC_SHIFT);
        icand = sat32(integ + mul_shift(gain_i, inc, FB));
        icand = clamp(icand, lim_ilo, lim_ihi);
        ocand = p + icand + d;
        if ((ocand <= lim_ohi && ocand >= lim_olo) || (ocand > lim_ohi && e0 < 0) ||
            (ocand < lim_olo && e0 > 0))
          integ = icand;
        res = clamp(p + integ + d, lim_olo, lim_ohi);
        last_meas = ms;
        last_err = e0;
        r.skipped = 0;
        r.drive = res[DW-1:0];
      end
      pending.push_back(r);
    endfunction

    function void check_output(logic [DW-1:0] drv, logic skp);
      pid_out_t x;
      if (pending.size() == 0) begin
        $error("unexpected output transaction drive=%h", drv);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x.drive !== drv) begin
        $error("drive: expected %h actual %h", x.drive, drv);
        errors++;
      end
      if (x.skipped !== skp) begin
        $error("skipped: expected %b actual %b", x.skipped, skp);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [TDW-1:0] s_axis_tdata;
  logic [0:0] s_axis_tuser, m_axis_tuser;
  logic [DW-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [DW-1:0] cfg_wdata_i;

  pid_scoreboard board;
  int send_idle_pct, recv_idle_pct;

  pid_trapezoid_antiwindup dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("pid_trapezoid_antiwindup test failed");
    $finish;
  end

  // Receiver: random stalls, checks each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_output(m_axis_tdata[DW-1:0], m_axis_tuser[0]);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Write enable stays up for back-to-back writes; set_all drops it
  task automatic cfg_write(reg_idx_e idx, logic [DW-1:0] v);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    board.write_reg(idx, v);
  endtask

  // tvalid stays up after acceptance until the next idle cycle or drain
  task automatic send_item(bit act, logic [DW-1:0] sp, logic [DW-1:0] ms, logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= TDW'({dt, ms, sp});
    s_axis_tuser <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(act, sp, ms, dt);
  endtask

  // Wait until all results are back, then the in-flight margin
  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] rand_val(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h000A0000) - 32'h00050000;
      2: return $urandom() & 32'hFFFF0000;
      default: return $urandom_range(3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
    endcase
  endfunction

  task automatic set_all(logic [DW-1:0] kp, ki, kd, olo, ohi, ilo, ihi);
    cfg_write(REG_KP, kp); cfg_write(REG_KI, ki); cfg_write(REG_KD, kd);
    cfg_write(REG_OUT_LOW, olo); cfg_write(REG_OUT_HIGH, ohi);
    cfg_write(REG_INTEG_LOW, ilo); cfg_write(REG_INTEG_HIGH, ihi);
    cfg_we_i <= 0;
  endtask

  initial begin
    logic [DW-1:0] sp, ms;
    board = new();
    board.clear_loop();
    board.errors = 0;
    {board.gain_p, board.gain_i, board.gain_d} = '0;
    {board.lim_olo, board.lim_ohi, board.lim_ilo, board.lim_ihi} = '0;
    send_idle_pct = 26; recv_idle_pct = 47;
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 0; cfg_we_i = 0; cfg_index_i = REG_KP; cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: zero gains, skip and reset cases
    send_item(0, 32'h00010000, 0, 16'h0100);
    send_item(0, 0, 0, 0);
    send_item(1, 0, 0, 16'h0100);
    drain();
    set_all(32'h00020000, 32'h00010000, 32'h00000800, 32'hFFF60000, 32'h000A0000,
            32'hFFFB0000, 32'h00050000);
    // first compute primes, then ramps with measurement steps
    send_item(0, 32'h00030000, 32'h00010000, 16'h0400);
    send_item(0, 32'h00030000, 32'h00018000, 16'h0400);
    send_item(0, 32'h00030000, 32'h00020000, 16'hFFFF);
    send_item(0, 32'h00030000, 32'h00020000, 16'h0001);
    send_item(0, 32'h00030000, 32'h00025000, 16'h0000);
    send_item(0, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
    send_item(0, 32'h80000000, 32'h7FFFFFFF, 16'h0001);
    send_item(0, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
    send_item(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_item(0, 32'hFFFFFFFF, 32'h00000000, 16'h5555);
    send_item(0, 32'h00000000, 32'hFFFFFFFF, 16'hAAAA);
    drain();
    // Extreme gains with crossed limits
    set_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00050000, 32'hFFFB0000,
            32'h00030000, 32'hFFFD0000);
    send_item(0, 32'h00010000, 0, 16'h1000);
    send_item(0, 32'h80000000, 32'h7FFFFFFF, 16'h0001);
    send_item(0, 32'h7FFFFFFF, 32'h80000000, 16'h0002);
    drain();
    set_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
            32'h80000000, 32'h7FFFFFFF);
    send_item(0, 32'h12345678, 32'h87654321, 16'hFFFF);
    send_item(0, 32'h7FFFFFFF, 32'h80000000, 16'h0001);
    send_item(0, 32'h80000000, 32'h7FFFFFFF, 16'h0001);
    drain();

    // Random phases: idle mix changes, gains and limits change
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin send_idle_pct = 47; recv_idle_pct = 26; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph % 2 == 0)
        set_all(rand_val(1) << 2, rand_val(1), rand_val(1) >> 4, 32'hFFF00000 | $urandom,
                32'h000FFFFF & $urandom, 32'hFFF80000 | $urandom, 32'h0007FFFF & $urandom);
      else
        set_all(rand_val(ph % 4), rand_val((ph + 1) % 4), rand_val(ph % 4), rand_val(0),
                rand_val(0), rand_val(3), rand_val(0));
      for (int k = 0; k < 48; k++) begin
        sp = rand_val($urandom_range(9) < 7 ? 1 : $urandom_range(3));
        ms = rand_val($urandom_range(9) < 7 ? 1 : $urandom_range(3));
        send_item($urandom_range(29) == 0, sp, ms,
                  $urandom_range(9) == 0 ? 16'h0000 :
                  ($urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(1, 16'h0800))));
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("pid_trapezoid_antiwindup test passed");
    else
      $display("pid_trapezoid_antiwindup test failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/pta_pkg.sv
design/pta_mul.sv
design/pta_div.sv
design/pta_dp.sv
design/pta_ctrl.sv
design/pid_trapezoid_antiwindup.sv
test/tb_pid_trapezoid_antiwindup.sv
